/* design/sfcrc_pkg.sv */
package sfcrc_pkg;

  localparam int FRAME_MAX = 32;
  localparam int IDX_W     = $clog2(FRAME_MAX);
  localparam int POS_W     = 6;

  localparam logic [POS_W-1:0] FRAME_MIN        = 6'd2;
  localparam logic [POS_W-1:0] FRAME_SIZE_RESET = 6'd28;
  localparam logic [POS_W-1:0] FRAME_LIMIT      = 6'(FRAME_MAX);

  localparam logic [7:0]  START_BYTE = 8'h80;
  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [2:0] KIND_XFER    = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_LOAD    = 3'd2;
  localparam logic [2:0] KIND_READ    = 3'd3;
  localparam logic [2:0] KIND_ACK     = 3'd4;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OK   = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_START,
    SEL_TX,
    SEL_CRC_LO,
    SEL_CRC_HI
  } reply_sel_t;

  typedef enum logic [1:0] {
    CRC_HOLD,
    CRC_INIT,
    CRC_UPDATE
  } crc_op_t;

  typedef struct packed {
    reply_sel_t sel;
    crc_op_t    op;
    logic       rd_en;
    logic [1:0] status;
  } ctl_t;

  // Reflected CRC-16 update by one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/spi_slave_frame_crc16_unit.sv */
// SPI slave frame engine with CRC-16 (reflected, polynomial 0xA001, seed 0xFFFF) on
// both directions. Every input word (byte exchanged, select released, transmit load,
// receive read, acknowledge) yields exactly one result word. A new word is accepted
// every clock cycle while results are taken. The accepting edge runs the frame state
// machine and the store accesses. When the output side is free, the staged word
// folds the sent byte into the transmit CRC and registers the reply. While out_ready
// is low, one more word can wait in the staging register, and then in_ready drops
// until the result is taken. frame_size may be written only while no word is in
// flight; values outside 2..32 are clamped.
module spi_slave_frame_crc16_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  kind,
  input  logic [7:0]                  data,
  input  logic [4:0]                  index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  reply_byte,
  output logic [1:0]                  status,
  output logic [7:0]                  read_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sfcrc_pkg::POS_W-1:0] cfg_data
);
  import sfcrc_pkg::*;

  logic       accept;
  ctl_t       ctl;
  logic [7:0] tx_byte;
  logic [7:0] rx_byte;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  sfcrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .kind     (kind),
    .data     (data),
    .index    (index),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .tx_byte  (tx_byte),
    .rx_byte  (rx_byte)
  );

  sfcrc_reply u_reply (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ctl         (ctl),
    .tx_byte     (tx_byte),
    .rx_byte     (rx_byte),
    .stage_ready (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .reply_byte  (reply_byte),
    .status      (status),
    .read_data   (read_data)
  );

endmodule

/* design/sfcrc_ctrl.sv */
module sfcrc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [2:0]                kind,
  input  logic [7:0]                data,
  input  logic [sfcrc_pkg::IDX_W-1:0] index,
  input  logic                      cfg_we,
  input  logic [sfcrc_pkg::POS_W-1:0] cfg_data,
  output sfcrc_pkg::ctl_t           ctl,
  output logic [7:0]                tx_byte,
  output logic [7:0]                rx_byte
);
  import sfcrc_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_REPLY,
    PH_DATA,
    PH_CRC_LOW,
    PH_CRC_HIGH,
    PH_CRC_CHECK,
    PH_RELEASE
  } phase_t;

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  frame_size;
  logic [POS_W-1:0]  send_position, send_position_next;
  logic [POS_W-1:0]  receive_position, receive_position_next;
  logic [15:0]       receive_check, receive_check_next;
  logic [7:0]        partner_check_low, partner_check_low_next;
  logic [1:0]        pending_status, pending_status_next;
  logic [1:0]        current_status, current_status_next;
  logic              bank_select, bank_select_next;
  ctl_t              ctl_next;
  logic              tx_we, rx_we;
  logic [POS_W-1:0]  eff_size;
  logic [POS_W-1:0]  send_inc;

  logic [7:0] tx_mem [FRAME_MAX];
  logic [7:0] rx_mem [2*FRAME_MAX];

  always_comb begin
    if (frame_size < FRAME_MIN) begin
      eff_size = FRAME_MIN;
    end else if (frame_size > FRAME_LIMIT) begin
      eff_size = FRAME_LIMIT;
    end else begin
      eff_size = frame_size;
    end
  end

  assign send_inc = send_position + 6'd1;

  always_comb begin
    phase_next             = phase;
    send_position_next     = send_position;
    receive_position_next  = receive_position;
    receive_check_next     = receive_check;
    partner_check_low_next = partner_check_low;
    pending_status_next    = pending_status;
    current_status_next    = current_status;
    bank_select_next       = bank_select;
    ctl_next.sel           = SEL_ZERO;
    ctl_next.op            = CRC_HOLD;
    ctl_next.rd_en         = 1'b0;
    tx_we                  = 1'b0;
    rx_we                  = 1'b0;

    unique case (kind)
      KIND_XFER: begin
        unique case (phase)
          PH_WAIT: begin
            current_status_next = ST_RUN;
            if (data == START_BYTE) begin
              receive_check_next    = CRC_SEED;
              send_position_next    = '0;
              receive_position_next = '0;
              ctl_next.sel          = SEL_START;
              ctl_next.op           = CRC_INIT;
              phase_next            = PH_REPLY;
            end
          end
          PH_REPLY: begin
            if (data == SYNC_BYTE) begin
              ctl_next.sel       = SEL_TX;
              ctl_next.op        = CRC_UPDATE;
              send_position_next = send_inc;
              phase_next         = PH_DATA;
            end else begin
              phase_next = PH_RELEASE;
            end
          end
          PH_DATA: begin
            rx_we                 = (receive_position < FRAME_LIMIT);
            receive_position_next = receive_position + 6'd1;
            receive_check_next    = crc16_byte(receive_check, data);
            ctl_next.sel          = SEL_TX;
            ctl_next.op           = CRC_UPDATE;
            send_position_next    = send_inc;
            if (send_inc >= eff_size) begin
              phase_next = PH_CRC_LOW;
            end
          end
          PH_CRC_LOW: begin
            rx_we                 = (receive_position < FRAME_LIMIT);
            receive_position_next = receive_position + 6'd1;
            receive_check_next    = crc16_byte(receive_check, data);
            ctl_next.sel          = SEL_CRC_LO;
            phase_next            = PH_CRC_HIGH;
          end
          PH_CRC_HIGH: begin
            ctl_next.sel           = SEL_CRC_HI;
            partner_check_low_next = data;
            phase_next             = PH_CRC_CHECK;
          end
          PH_CRC_CHECK: begin
            if ({data, partner_check_low} == receive_check) begin
              bank_select_next    = ~bank_select;
              pending_status_next = ST_OK;
            end else begin
              pending_status_next = ST_ERR;
            end
            ctl_next.sel = SEL_START;
            phase_next   = PH_RELEASE;
          end
          default: begin
          end
        endcase
      end
      KIND_RELEASE: begin
        current_status_next = (phase == PH_RELEASE) ? pending_status : ST_IDLE;
        phase_next          = PH_WAIT;
      end
      KIND_LOAD: begin
        tx_we = (current_status == ST_IDLE);
      end
      KIND_READ: begin
        ctl_next.rd_en = 1'b1;
      end
      KIND_ACK: begin
        current_status_next = ST_IDLE;
        pending_status_next = ST_IDLE;
      end
      default: begin
      end
    endcase

    ctl_next.status = current_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAIT;
      frame_size        <= FRAME_SIZE_RESET;
      send_position     <= '0;
      receive_position  <= '0;
      receive_check     <= CRC_SEED;
      partner_check_low <= '0;
      pending_status    <= ST_IDLE;
      current_status    <= ST_IDLE;
      bank_select       <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_size <= cfg_data;
      end
      if (accept) begin
        phase             <= phase_next;
        send_position     <= send_position_next;
        receive_position  <= receive_position_next;
        receive_check     <= receive_check_next;
        partner_check_low <= partner_check_low_next;
        pending_status    <= pending_status_next;
        current_status    <= current_status_next;
        bank_select       <= bank_select_next;
      end
    end
    if (accept) begin
      ctl <= ctl_next;
    end
  end

  // The transmit byte is read at the current send position; the sent CRC is
  // folded in one stage later, once the read data is out of the memory.
  always_ff @(posedge clk) begin
    if (accept && tx_we) begin
      tx_mem[index] <= data;
    end
    if (accept) begin
      tx_byte <= tx_mem[send_position[IDX_W-1:0]];
    end
  end

  // Words are filled into one bank while reads come from the other one.
  always_ff @(posedge clk) begin
    if (accept && rx_we) begin
      rx_mem[{bank_select, receive_position[IDX_W-1:0]}] <= data;
    end
    if (accept) begin
      rx_byte <= rx_mem[{~bank_select, index}];
    end
  end

endmodule

/* design/sfcrc_reply.sv */
module sfcrc_reply (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  sfcrc_pkg::ctl_t ctl,
  input  logic [7:0]      tx_byte,
  input  logic [7:0]      rx_byte,
  output logic            stage_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      reply_byte,
  output logic [1:0]      status,
  output logic [7:0]      read_data
);
  import sfcrc_pkg::*;

  logic        b_valid;
  logic        b_advance;
  logic [15:0] send_check, send_check_next;
  logic [7:0]  reply_next;

  assign b_advance   = b_valid && (!out_valid || out_ready);
  assign stage_ready = !b_valid || b_advance;

  always_comb begin
    case (ctl.sel)
      SEL_START:  reply_next = START_BYTE;
      SEL_TX:     reply_next = tx_byte;
      SEL_CRC_LO: reply_next = send_check[7:0];
      SEL_CRC_HI: reply_next = send_check[15:8];
      default:    reply_next = 8'h00;
    endcase
  end

  always_comb begin
    case (ctl.op)
      CRC_INIT:   send_check_next = CRC_SEED;
      CRC_UPDATE: send_check_next = crc16_byte(send_check, tx_byte);
      default:    send_check_next = send_check;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      out_valid  <= 1'b0;
      send_check <= CRC_SEED;
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_advance) begin
        b_valid <= 1'b0;
      end
      if (b_advance) begin
        out_valid  <= 1'b1;
        send_check <= send_check_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (b_advance) begin
      reply_byte <= reply_next;
      status     <= ctl.status;
      read_data  <= ctl.rd_en ? rx_byte : 8'h00;
    end
  end

endmodule

/* design/sfcrc_checker.sv */
module sfcrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] reply_byte,
  input logic [1:0] status,
  input logic [7:0] read_data
);

  // A stalled result word holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reply_byte) && $stable(status)
      && $stable(read_data))
    else $error("result word changed while stalled");

  // Only an exchange answers a byte and only a read returns data.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reply_byte == 8'h00 || read_data == 8'h00)
    else $error("reply byte and read data both nonzero");

  // With the output side empty the input side must take a word.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word presented right after reset");

endmodule

bind spi_slave_frame_crc16_unit sfcrc_checker u_checker (.*);

/* sim/tb_spi_slave_frame_crc16_unit.sv */
`timescale 1ns / 1ps

module tb_spi_slave_frame_crc16_unit;
  import sfcrc_pkg::*;

  typedef enum int {
    PH_WAIT,
    PH_SYNC,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_CRC_CHK,
    PH_END
  } frame_phase_t;

  typedef struct {
    logic [7:0] reply;
    logic [1:0] status;
    logic [7:0] rd;
  } reply_word_t;

  // Mirrors the frame engine and holds the reply words still owed by the block.
  class crc_frame_tracker;
    logic [5:0]   frame_size;
    frame_phase_t ph;
    int           tx_pos;
    int           rx_pos;
    logic [15:0]  tx_crc;
    logic [15:0]  rx_crc;
    logic [7:0]   peer_lo;
    logic [1:0]   pend_status;
    logic [1:0]   cur_status;
    bit           fill_bank;
    logic [7:0]   tx_mem [FRAME_MAX];
    logic [7:0]   rx_mem [2][FRAME_MAX];
    bit           rx_written [2][FRAME_MAX];
    reply_word_t  awaited_replies [$];
    int           mismatches;

    function new();
      frame_size  = FRAME_SIZE_RESET;
      ph          = PH_WAIT;
      tx_pos      = 0;
      rx_pos      = 0;
      tx_crc      = CRC_SEED;
      rx_crc      = CRC_SEED;
      peer_lo     = 8'h00;
      pend_status = ST_IDLE;
      cur_status  = ST_IDLE;
      fill_bank   = 1'b0;
      mismatches  = 0;
      foreach (rx_written[b, j]) rx_written[b][j] = 1'b0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function int frame_len();
      if (frame_size < FRAME_MIN) return FRAME_MIN;
      if (frame_size > FRAME_LIMIT) return FRAME_LIMIT;
      return frame_size;
    endfunction

    function logic [7:0] next_tx();
      logic [7:0] b;
      b = (tx_pos < FRAME_MAX) ? tx_mem[tx_pos] : 8'h00;
      tx_pos++;
      tx_crc = crc_step(tx_crc, b);
      return b;
    endfunction

    function void take_rx(logic [7:0] b);
      if (rx_pos < FRAME_MAX) begin
        rx_mem[fill_bank][rx_pos] = b;
        rx_written[fill_bank][rx_pos] = 1'b1;
      end
      rx_pos++;
      rx_crc = crc_step(rx_crc, b);
    endfunction

    function void note_word(logic [2:0] k, logic [7:0] d, logic [4:0] i);
      reply_word_t r;
      r.reply = 8'h00;
      r.rd = 8'h00;
      case (k)
        KIND_XFER: begin
          case (ph)
            PH_WAIT: begin
              cur_status = ST_RUN;
              if (d == START_BYTE) begin
                tx_crc = CRC_SEED;
                rx_crc = CRC_SEED;
                tx_pos = 0;
                rx_pos = 0;
                r.reply = START_BYTE;
                ph = PH_SYNC;
              end
            end
            PH_SYNC: begin
              if (d == SYNC_BYTE) begin
                r.reply = next_tx();
                ph = PH_DATA;
              end else begin
                ph = PH_END;
              end
            end
            PH_DATA: begin
              take_rx(d);
              r.reply = next_tx();
              if (tx_pos >= frame_len()) ph = PH_CRC_LO;
            end
            PH_CRC_LO: begin
              take_rx(d);
              r.reply = tx_crc[7:0];
              ph = PH_CRC_HI;
            end
            PH_CRC_HI: begin
              r.reply = tx_crc[15:8];
              peer_lo = d;
              ph = PH_CRC_CHK;
            end
            PH_CRC_CHK: begin
              if ({d, peer_lo} == rx_crc) begin
                fill_bank = !fill_bank;
                pend_status = ST_OK;
              end else begin
                pend_status = ST_ERR;
              end
              r.reply = START_BYTE;
              ph = PH_END;
            end
            default: r.reply = 8'h00;
          endcase
        end
        KIND_RELEASE: begin
          cur_status = (ph == PH_END) ? pend_status : ST_IDLE;
          ph = PH_WAIT;
        end
        KIND_LOAD: begin
          if (cur_status == ST_IDLE) tx_mem[i] = d;
        end
        KIND_READ: r.rd = rx_mem[!fill_bank][i];
        KIND_ACK: begin
          cur_status = ST_IDLE;
          pend_status = ST_IDLE;
        end
        default: ;
      endcase
      r.status = cur_status;
      awaited_replies.push_back(r);
    endfunction

    function void check_reply(logic [7:0] reply, logic [1:0] status, logic [7:0] rd);
      reply_word_t e;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result word: reply_byte %02h status %0d read_data %02h",
                 $time, reply, status, rd);
        mismatches++;
      end else begin
        e = awaited_replies.pop_front();
        if (reply !== e.reply) begin
          $display("%0t: reply_byte expected %02h actual %02h", $time, e.reply, reply);
          mismatches++;
        end
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          mismatches++;
        end
        if (rd !== e.rd) begin
          $display("%0t: read_data expected %02h actual %02h", $time, e.rd, rd);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [2:0]       kind;
  logic [7:0]       data;
  logic [4:0]       index;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       reply_byte;
  logic [1:0]       status;
  logic [7:0]       read_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [POS_W-1:0] cfg_data;

  crc_frame_tracker tracker;
  int               sent_words;
  bit               calm;
  bit               hold_req;

  spi_slave_frame_crc16_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .data      (data),
    .index     (index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .reply_byte(reply_byte),
    .status    (status),
    .read_data (read_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [4:0] rand_index();
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic send_word(logic [2:0] k, logic [7:0] d, logic [4:0] i);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    data <= d;
    index <= i;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(k, d, i);
    sent_words++;
  endtask

  // Drops valid and waits until every owed result word has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_size(logic [5:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.frame_size = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic read_back(int n);
    int start;
    int idx;
    bit rb;
    repeat (n) begin
      rb = !tracker.fill_bank;
      start = $urandom_range(0, FRAME_MAX - 1);
      // Only entries of the read bank that some frame has actually written are read.
      for (int j = 0; j < FRAME_MAX; j++) begin
        idx = (start + j) % FRAME_MAX;
        if (tracker.rx_written[rb][idx]) break;
      end
      if (tracker.rx_written[rb][idx]) send_word(KIND_READ, rand_byte(), 5'(idx));
    end
  endtask

  // Sends start, sync, payload and CRC, then a release; cut >= 0 stops after that many bytes.
  task automatic run_frame(int fill, bit corrupt, int cut);
    logic [7:0]  seq [$];
    logic [15:0] c;
    logic [7:0]  b;
    int          n;
    int          lim;
    n = tracker.frame_len();
    c = CRC_SEED;
    seq.push_back(START_BYTE);
    seq.push_back(SYNC_BYTE);
    for (int j = 0; j < n; j++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      seq.push_back(b);
      c = tracker.crc_step(c, b);
    end
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
    seq.push_back(c[7:0]);
    seq.push_back(c[15:8]);
    lim = (cut >= 0 && cut < seq.size()) ? cut : seq.size();
    for (int j = 0; j < lim; j++) begin
      if (!calm && $urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0: read_back(1);
          1: send_word(KIND_ACK, rand_byte(), rand_index());
          default: send_word(3'($urandom_range(5, 7)), rand_byte(), rand_index());
        endcase
      end
      send_word(KIND_XFER, seq[j], rand_index());
    end
    if (lim == seq.size()) begin
      repeat ($urandom_range(0, 2)) send_word(KIND_XFER, rand_byte(), rand_index());
    end
    send_word(KIND_RELEASE, rand_byte(), rand_index());
  endtask

  // Receiver side: random stalls, plus one long hold on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_reply(reply_byte, status, read_data);
    end
  end

  initial begin
    logic [5:0] sizes [10];
    int         next_cfg;
    int         pick;
    bit         held;
    sizes = '{6'd2, 6'd32, 6'd1, 6'd33, 6'd5, 6'd28, 6'd17, 6'd3, 6'd31, 6'd63};
    tracker = new();
    sent_words = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    held = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_XFER;
    data = 8'h00;
    index = 5'd0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every transmit entry is loaded before any frame can send from it.
    for (int j = 0; j < FRAME_MAX; j++) begin
      send_word(KIND_LOAD, (j == 0) ? 8'h00 : (j == 1) ? 8'hFF : 8'($urandom), 5'(j));
    end

    send_word(3'd5, 8'hFF, 5'd31);
    send_word(3'd6, 8'h00, 5'd0);
    send_word(3'd7, 8'h55, 5'd21);
    send_word(KIND_XFER, 8'hAA, 5'd0);
    send_word(KIND_LOAD, 8'h5A, 5'd0);
    send_word(KIND_RELEASE, 8'h00, 5'd0);
    send_word(KIND_XFER, START_BYTE, 5'd0);
    send_word(KIND_XFER, 8'h12, 5'd0);
    send_word(KIND_XFER, SYNC_BYTE, 5'd0);
    send_word(KIND_RELEASE, 8'h00, 5'd0);
    set_frame_size(6'd0);
    run_frame(8'h00, 1'b0, -1);
    read_back(2);
    send_word(KIND_ACK, 8'h00, 5'd0);
    run_frame(8'hFF, 1'b1, -1);
    send_word(KIND_ACK, 8'h00, 5'd0);
    run_frame(-1, 1'b0, 3);
    set_frame_size(6'd63);
    run_frame(-1, 1'b0, -1);
    read_back(3);
    send_word(KIND_ACK, 8'h00, 5'd0);

    next_cfg = sent_words + 250;
    while (sent_words < 1400) begin
      if (sent_words >= next_cfg) begin
        calm = 1'b0;
        set_frame_size(($urandom_range(0, 1) == 0) ? sizes[$urandom_range(0, 9)] :
                       6'($urandom_range(0, 63)));
        next_cfg += 250;
      end
      calm = ($urandom_range(0, 9) == 0);
      // The sender keeps offering words while the receiver holds off, so the block fills.
      if (!held && sent_words >= 700) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_frame(-1, $urandom_range(0, 6) == 0, -1);
        read_back($urandom_range(0, 3));
        if ($urandom_range(0, 4) != 0) begin
          send_word(KIND_ACK, rand_byte(), rand_index());
          repeat ($urandom_range(0, 4)) send_word(KIND_LOAD, rand_byte(), rand_index());
        end
      end else if (pick < 78) begin
        run_frame(-1, 1'b0, $urandom_range(1, tracker.frame_len() + 3));
      end else if (pick < 85) begin
        send_word(KIND_XFER, START_BYTE, rand_index());
        send_word(KIND_XFER, 8'($urandom_range(0, 254)), rand_index());
        repeat ($urandom_range(0, 2)) send_word(KIND_XFER, rand_byte(), rand_index());
        send_word(KIND_RELEASE, rand_byte(), rand_index());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 7);
          if (pick == KIND_READ) read_back(1);
          else send_word(3'(pick), rand_byte(), rand_index());
        end
        send_word(KIND_RELEASE, rand_byte(), rand_index());
      end
    end

    calm = 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb_spi_slave_frame_crc16_unit: clean");
    end else begin
      $display("tb_spi_slave_frame_crc16_unit: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: run did not finish in time", $time);
    $display("tb_spi_slave_frame_crc16_unit: errors");
    $finish;
  end

endmodule

/* spi_slave_frame_crc16_unit.f */
design/sfcrc_pkg.sv
design/sfcrc_ctrl.sv
design/sfcrc_reply.sv
design/spi_slave_frame_crc16_unit.sv
design/sfcrc_checker.sv
sim/tb_spi_slave_frame_crc16_unit.sv
